@@ src/fsa_pkg.sv @@
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared widths, codes, stride table and the scan wave type of the
// frame slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

	localparam int MAX_SLOTS_DEF = 32;
	localparam int ADDR_W        = 32;
	localparam int BYTES_W       = 28;
	localparam int OFF_W         = 28;
	localparam int STRIDE_W      = 21;
	localparam int IDX_W         = 6;
	localparam int MODE_W        = 3;

	localparam logic [BYTES_W-1:0] HEAP_BYTES_RST = 28'd16777216;
	localparam logic [MODE_W-1:0]  MODE_RST       = 3'd7;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_MODE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		REG_HEAP_BASE  = 1'b0,
		REG_HEAP_BYTES = 1'b1
	} reg_idx_t;

	localparam logic [STRIDE_W-1:0] MODE_STRIDE [8] = '{
		21'd102912,
		21'd147648,
		21'd284992,
		21'd410112,
		21'd641024,
		21'd921600,
		21'd1255168,
		21'd1639680
	};

	typedef struct packed {
		logic                vld;
		logic                alloc;
		logic                claimed;
		logic [IDX_W-1:0]    res_idx;
		logic [ADDR_W-1:0]   res_addr;
		logic [ADDR_W-1:0]   tgt;
		logic [OFF_W-1:0]    offset;
		logic [STRIDE_W-1:0] stride;
	} wave_t;

endpackage

@@ src/fsa_cell.sv @@
// ----------------------------------------------------------------------------
// fsa_cell
// One slot of the allocator: holds the used bit, claims or clears it as the
// scan wave passes, and hands the wave on to the next slot.
// ----------------------------------------------------------------------------
module fsa_cell
	import fsa_pkg::*;
#(
	parameter int SLOT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ADDR_W-1:0]  heap_base,
	input  logic [BYTES_W-1:0] heap_bytes,
	input  wave_t              wave_in,
	output wave_t              wave_out,
	output logic               used
);

	logic              used_q;
	logic              vld_q;
	wave_t             wave_q;
	wave_t             wave_d;
	logic              in_range;
	logic [ADDR_W-1:0] slot_addr;
	logic              take;
	logic              drop;

	assign in_range  = ((OFF_W+1)'(wave_in.offset) + (OFF_W+1)'(wave_in.stride))
			<= (OFF_W+1)'(heap_bytes);
	assign slot_addr = heap_base + ADDR_W'(wave_in.offset);
	assign take      = wave_in.vld & in_range & wave_in.alloc & ~wave_in.claimed & ~used_q;
	assign drop      = wave_in.vld & in_range & ~wave_in.alloc & (slot_addr == wave_in.tgt);

	always_comb begin
		wave_d        = wave_in;
		wave_d.offset = wave_in.offset + OFF_W'(wave_in.stride);
		if (take) begin
			wave_d.claimed  = 1'b1;
			wave_d.res_idx  = IDX_W'(SLOT);
			wave_d.res_addr = slot_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_q <= wave_in.vld;
			if (take) begin
				used_q <= 1'b1;
			end else if (drop) begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wave_q <= wave_d;
	end

	always_comb begin
		wave_out     = wave_q;
		wave_out.vld = vld_q;
	end

	assign used = used_q;

endmodule

@@ src/frame_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// frame_slot_allocator_unit
// Bitmap frame slot allocator: a chain of slot cells scanned by a wave that
// carries the running slot offset, for allocate and free items.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  item in   operation, address, new_mode              start & !busy
//  result    granted, slot_index, slot_address          done, one cycle
//  config    cfg_index, cfg_data                        cfg_valid & cfg_ready
//
//  Allocate and free: the wave walks one slot per cycle, done is registered
//  from the wave leaving the last slot; busy falls as done rises.
//  Mode change, a failed allocate while draining and op 3: done next cycle.
//  Reset frees every slot, mode 7, no drain pending.
//  Results cannot be held off; cfg_ready is low while busy.
// ----------------------------------------------------------------------------
module frame_slot_allocator_unit
	import fsa_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [ADDR_W-1:0]  address,
	input  logic [MODE_W-1:0]  new_mode,
	output logic               done,
	output logic               granted,
	output logic [IDX_W-1:0]   slot_index,
	output logic [ADDR_W-1:0]  slot_address,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [ADDR_W-1:0]  cfg_data
);

	logic [ADDR_W-1:0]  heap_base_q;
	logic [BYTES_W-1:0] heap_bytes_q;
	logic [MODE_W-1:0]  cur_mode_q;
	logic [MODE_W-1:0]  drain_mode_q;
	logic               drain_q;
	logic               busy_q;
	logic               done_q;
	logic               granted_q;
	logic [IDX_W-1:0]   slot_index_q;
	logic [ADDR_W-1:0]  slot_address_q;
	logic               inj_vld_q;
	wave_t              inj_q;
	wave_t              waves [MAX_SLOTS+1];
	logic [MAX_SLOTS-1:0] used_w;
	logic               accept;
	logic               any_used;
	wave_t              exit_w;
	op_t                op;

	assign op       = op_t'(operation);
	assign accept   = start & ~busy_q;
	assign any_used = |used_w;
	assign exit_w   = waves[MAX_SLOTS];

	always_comb begin
		waves[0]     = inj_q;
		waves[0].vld = inj_vld_q;
	end

	for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
		fsa_cell #(
			.SLOT(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.heap_base  (heap_base_q),
			.heap_bytes (heap_bytes_q),
			.wave_in    (waves[k]),
			.wave_out   (waves[k+1]),
			.used       (used_w[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q    <= '0;
			heap_bytes_q   <= HEAP_BYTES_RST;
			cur_mode_q     <= MODE_RST;
			drain_mode_q   <= '0;
			drain_q        <= 1'b0;
			busy_q         <= 1'b0;
			done_q         <= 1'b0;
			granted_q      <= 1'b0;
			slot_index_q   <= '0;
			slot_address_q <= '0;
			inj_vld_q      <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			inj_vld_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_HEAP_BASE:  heap_base_q  <= cfg_data;
					REG_HEAP_BYTES: heap_bytes_q <= cfg_data[BYTES_W-1:0];
					default:        heap_base_q  <= heap_base_q;
				endcase
			end
			if (exit_w.vld) begin
				busy_q         <= 1'b0;
				done_q         <= 1'b1;
				granted_q      <= exit_w.claimed;
				slot_index_q   <= exit_w.res_idx;
				slot_address_q <= exit_w.res_addr;
			end
			if (accept) begin
				granted_q      <= 1'b0;
				slot_index_q   <= '0;
				slot_address_q <= '0;
				case (op)
					OP_ALLOC: begin
						if (drain_q && any_used) begin
							done_q <= 1'b1;
						end else begin
							drain_q   <= 1'b0;
							busy_q    <= 1'b1;
							inj_vld_q <= 1'b1;
						end
					end
					OP_FREE: begin
						busy_q    <= 1'b1;
						inj_vld_q <= 1'b1;
					end
					OP_MODE: begin
						if (!drain_q) begin
							drain_mode_q <= cur_mode_q;
							drain_q      <= 1'b1;
						end
						cur_mode_q <= new_mode;
						done_q     <= 1'b1;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inj_q.vld      <= 1'b0;
			inj_q.alloc    <= (op == OP_ALLOC);
			inj_q.claimed  <= 1'b0;
			inj_q.res_idx  <= '0;
			inj_q.res_addr <= '0;
			inj_q.tgt      <= address;
			inj_q.offset   <= '0;
			inj_q.stride   <= MODE_STRIDE[(op == OP_FREE && drain_q) ? drain_mode_q
					: cur_mode_q];
		end
	end

	assign busy         = busy_q;
	assign cfg_ready    = ~busy_q;
	assign done         = done_q;
	assign granted      = granted_q;
	assign slot_index   = slot_index_q;
	assign slot_address = slot_address_q;

endmodule

@@ src/fsa_checker.sv @@
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks on the frame slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fsa_checker
	import fsa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         operation,
	input logic               done,
	input logic               granted,
	input logic [IDX_W-1:0]   slot_index,
	input logic [ADDR_W-1:0]  slot_address,
	input logic               cfg_ready
);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !granted |-> slot_index == '0 && slot_address == '0)
		else $error("failed item carries a slot");

	a_mode_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_MODE |=> done && !granted && !busy)
		else $error("mode change item not answered at once");

	a_free_scan: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_FREE |=> busy && !done)
		else $error("free item did not start a scan");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("config open during a scan");

endmodule

bind frame_slot_allocator_unit fsa_checker u_fsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.operation    (operation),
	.done         (done),
	.granted      (granted),
	.slot_index   (slot_index),
	.slot_address (slot_address),
	.cfg_ready    (cfg_ready)
);
